// ===== sv/tlpc_pkg.sv =====
// ============================================================================
// tlpc_pkg
// Types, codes and fixed-point constants of the tank level pump controller.
// ============================================================================
`default_nettype none

package tlpc_pkg;

    // ------------------------------------------------------------------------
    // Payload types
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [2:0]  operation;
        logic [14:0] echo_time;
        logic        set_value;
    } req_t;

    typedef struct packed {
        logic [6:0] level_percent;
        logic       pump_on;
        logic       automatic_mode;
        logic [4:0] led_bar;
        logic       buzzer;
        logic       level_updated;
    } rsp_t;

    typedef struct packed {
        logic [6:0]  pump_start_level;
        logic [6:0]  pump_stop_level;
        logic [8:0]  filter_gain;
        logic [15:0] min_valid_distance;
        logic [15:0] max_valid_distance;
    } cfg_t;

    // ------------------------------------------------------------------------
    // Operation codes
    // ------------------------------------------------------------------------
    localparam logic [2:0] OP_ECHO            = 3'd0;
    localparam logic [2:0] OP_MODE_BUTTON     = 3'd1;
    localparam logic [2:0] OP_PUMP_ON_BUTTON  = 3'd2;
    localparam logic [2:0] OP_PUMP_OFF_BUTTON = 3'd3;
    localparam logic [2:0] OP_REMOTE_MODE     = 3'd4;
    localparam logic [2:0] OP_REMOTE_PUMP     = 3'd5;

    // ------------------------------------------------------------------------
    // Configuration register indexes and reset values
    // ------------------------------------------------------------------------
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_PUMP_START   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PUMP_STOP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_GAIN  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_DISTANCE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DISTANCE = 3'd4;

    localparam cfg_t CFG_RESET = '{
        pump_start_level:   7'd10,
        pump_stop_level:    7'd90,
        filter_gain:        9'd38,
        min_valid_distance: 16'd240,
        max_valid_distance: 16'd2400
    };

    // ------------------------------------------------------------------------
    // Distance: d = floor(t * 343 / 125), exact reciprocal for t < 2^15
    // ------------------------------------------------------------------------
    localparam int                  ECHO_W       = 15;
    localparam int                  DIST_W       = 17;
    localparam int                  DIST_MUL_W   = 33;
    localparam int                  DIST_PROD_W  = ECHO_W + DIST_MUL_W;
    localparam int                  DIST_SHIFT   = 31;
    localparam logic [DIST_MUL_W-1:0] DIST_MUL   = 33'd5892695410;
    localparam logic [DIST_W-1:0]   TIMEOUT_DIST = 17'd1760;
    localparam logic [1:0]          POS_LAST     = 2'd2;

    // ------------------------------------------------------------------------
    // Map: q = floor((x - 20) * 10 / 9), exact reciprocal for x < 2^12
    // ------------------------------------------------------------------------
    localparam int                 X_W         = 12;
    localparam logic [X_W-1:0]     X_NONE      = 12'd110;
    localparam logic [X_W-1:0]     X_FULL      = 12'd20;
    localparam int                 MAP_MUL_W   = 21;
    localparam int                 MAP_PROD_W  = X_W + MAP_MUL_W;
    localparam int                 MAP_SHIFT   = 20;
    localparam logic [MAP_MUL_W-1:0] MAP_MUL   = 21'd1165090;
    localparam int                 Q_W         = 13;

    // ------------------------------------------------------------------------
    // Filter and level
    // ------------------------------------------------------------------------
    localparam int               LEVEL_W     = 7;
    localparam int               GAIN_W      = 9;
    localparam int               SMOOTH_W    = 15;
    localparam int               RAW_G_W     = 16;
    localparam int               DECAY_W     = 24;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;
    localparam logic [GAIN_W-1:0]  GAIN_MAX  = 9'd256;

    localparam logic [LEVEL_W-1:0] BAR_LEVEL_0 = 7'd5;
    localparam logic [LEVEL_W-1:0] BAR_LEVEL_1 = 7'd25;
    localparam logic [LEVEL_W-1:0] BAR_LEVEL_2 = 7'd50;
    localparam logic [LEVEL_W-1:0] BAR_LEVEL_3 = 7'd75;
    localparam logic [LEVEL_W-1:0] BAR_LEVEL_4 = 7'd95;
    localparam logic [LEVEL_W-1:0] BUZZ_LOW    = 7'd10;
    localparam logic [LEVEL_W-1:0] BUZZ_HIGH   = 7'd90;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIST,
        ST_MED,
        ST_ACC,
        ST_AVG,
        ST_MAP,
        ST_FILT_A,
        ST_FILT_B,
        ST_LEVEL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_req;
        logic exec_op;
        logic conv;
        logic med;
        logic acc;
        logic avg;
        logic map;
        logic filt_a;
        logic filt_b;
        logic level;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic req_echo;
        logic third;
        logic round_end;
        logic acc_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/tlpc_ctrl.sv =====
// ============================================================================
// tlpc_ctrl
// Sequencer: steps the datapath through one transaction at a time.
// ============================================================================
`default_nettype none

module tlpc_ctrl
    import tlpc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = status.req_echo ? ST_DIST : ST_EXEC;
                end
            end
            ST_EXEC:   state_next = ST_EMIT;
            ST_DIST:   state_next = status.third ? ST_MED : ST_EMIT;
            ST_MED:    state_next = status.round_end ? ST_ACC : ST_EMIT;
            ST_ACC:    state_next = status.acc_last ? ST_AVG : ST_ACC;
            ST_AVG:    state_next = ST_MAP;
            ST_MAP:    state_next = ST_FILT_A;
            ST_FILT_A: state_next = ST_FILT_B;
            ST_FILT_B: state_next = ST_LEVEL;
            ST_LEVEL:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        req_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.load_req = req_valid;
            end
            ST_EXEC:   cmd.exec_op = 1'b1;
            ST_DIST:   cmd.conv    = 1'b1;
            ST_MED:    cmd.med     = 1'b1;
            ST_ACC:    cmd.acc     = 1'b1;
            ST_AVG:    cmd.avg     = 1'b1;
            ST_MAP:    cmd.map     = 1'b1;
            ST_FILT_A: cmd.filt_a  = 1'b1;
            ST_FILT_B: cmd.filt_b  = 1'b1;
            ST_LEVEL:  cmd.level   = 1'b1;
            ST_EMIT:   cmd.emit    = status.out_free;
            default:   cmd         = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/tlpc_datapath.sv =====
// ============================================================================
// tlpc_datapath
// Echo conversion, median, averaging, level filter, pump logic, result register.
// ============================================================================
`default_nettype none

module tlpc_datapath
    import tlpc_pkg::*;
#(
    parameter int SENSOR_COUNT = 3
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire req_t    req,
    input  wire cfg_t    cfg,
    input  wire dp_cmd_t cmd,
    output dp_status_t   status,
    output logic         rsp_valid,
    input  wire logic    rsp_ready,
    output rsp_t         rsp
);

    localparam int SIDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int CNT_W  = $clog2(SENSOR_COUNT + 1);
    localparam int SUM_W  = 16 + $clog2(SENSOR_COUNT);
    localparam int Y_W    = SUM_W - 4;
    localparam int K3     = Y_W + 2;
    localparam int P3_W   = Y_W + K3;
    localparam logic [K3-1:0]     M3        = K3'((2 ** K3 + 2) / 3);
    localparam logic [SIDX_W-1:0] SENS_LAST = SIDX_W'(SENSOR_COUNT - 1);

    req_t                  req_reg;
    logic [DIST_W-1:0]     d_reg;
    logic [DIST_W-1:0]     e0_reg;
    logic [DIST_W-1:0]     e1_reg;
    logic [DIST_W-1:0]     med_chain_reg [SENSOR_COUNT];
    logic [1:0]            pos_reg;
    logic [SIDX_W-1:0]     sens_reg;
    logic [SIDX_W-1:0]     acc_reg;
    logic                  round_end_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [X_W-1:0]        x_reg;
    logic [Q_W-1:0]        q_reg;
    logic                  high_reg;
    logic [RAW_G_W-1:0]    raw_g_reg;
    logic [SMOOTH_W-1:0]   smooth_reg;
    logic [LEVEL_W-1:0]    rounded_reg;
    logic                  mode_reg;
    logic                  pump_reg;
    logic                  updated_reg;
    rsp_t                  rsp_reg;
    logic                  rsp_valid_reg;

    logic [DIST_PROD_W-1:0] dist_prod;
    logic [DIST_W-1:0]      dist_next;
    logic [DIST_W-1:0]      lo_dist;
    logic [DIST_W-1:0]      hi_dist;
    logic [DIST_W-1:0]      mid_dist;
    logic [DIST_W-1:0]      med_next;
    logic                   med_ok;
    logic [Y_W-1:0]         y_val;
    logic [P3_W-1:0]        div3_prod;
    logic [Y_W-1:0]         quot;
    logic [X_W-1:0]         x_next;
    logic [X_W-1:0]         diff;
    logic [MAP_PROD_W-1:0]  map_prod;
    logic [LEVEL_W-1:0]     raw_level;
    logic [GAIN_W-1:0]      gain;
    logic [GAIN_W-1:0]      keep;
    logic [DECAY_W-1:0]     decay;
    logic [SMOOTH_W-1:0]    smooth_next;
    logic [LEVEL_W-1:0]     level_new;
    logic [1:0]             pos_next;
    logic [SIDX_W-1:0]      sens_next;
    logic [SIDX_W-1:0]      acc_next;
    logic [SUM_W-1:0]       sum_next;
    logic [CNT_W-1:0]       cnt_next;
    logic [LEVEL_W-1:0]     rounded_next;
    logic                   mode_next;
    logic                   pump_next;
    logic                   updated_next;
    logic                   rsp_valid_next;
    rsp_t                   rsp_next;

    // ------------------------------------------------------------------------
    // Arithmetic
    // ------------------------------------------------------------------------
    assign dist_prod = DIST_PROD_W'(req_reg.echo_time) * DIST_PROD_W'(DIST_MUL);
    assign dist_next = (req_reg.echo_time == '0) ? TIMEOUT_DIST
                                                 : dist_prod[DIST_SHIFT +: DIST_W];

    assign lo_dist  = (e0_reg < e1_reg) ? e0_reg : e1_reg;
    assign hi_dist  = (e0_reg < e1_reg) ? e1_reg : e0_reg;
    assign mid_dist = (hi_dist < d_reg) ? hi_dist : d_reg;
    assign med_next = (lo_dist > mid_dist) ? lo_dist : mid_dist;

    assign med_ok = (med_chain_reg[0] >= DIST_W'(cfg.min_valid_distance))
                 && (med_chain_reg[0] <= DIST_W'(cfg.max_valid_distance));

    assign y_val     = sum_reg[SUM_W-1:4];
    assign div3_prod = P3_W'(y_val) * P3_W'(M3);

    always_comb
    begin
        unique case (3'(cnt_reg))
            3'd1:    quot = y_val;
            3'd2:    quot = y_val >> 1;
            3'd3:    quot = div3_prod[K3 +: Y_W];
            3'd4:    quot = y_val >> 2;
            default: quot = '0;
        endcase
    end

    assign x_next   = (cnt_reg == '0) ? X_NONE : quot[X_W-1:0];
    assign diff     = x_reg - X_FULL;
    assign map_prod = MAP_PROD_W'(diff) * MAP_PROD_W'(MAP_MUL);

    assign raw_level = high_reg                       ? LEVEL_MAX :
                       (q_reg >= Q_W'(LEVEL_MAX))     ? '0        :
                                                        LEVEL_MAX - q_reg[LEVEL_W-1:0];

    assign gain  = (cfg.filter_gain > GAIN_MAX) ? GAIN_MAX : cfg.filter_gain;
    assign keep  = GAIN_MAX - gain;
    assign decay = DECAY_W'(smooth_reg) * DECAY_W'(keep) + DECAY_W'(128);
    assign smooth_next = SMOOTH_W'(17'(raw_g_reg) + 17'(decay[DECAY_W-1:8]));

    assign level_new = LEVEL_W'((16'(smooth_reg) + 16'd128) >> 8);

    // ------------------------------------------------------------------------
    // State update
    // ------------------------------------------------------------------------
    always_comb
    begin
        pos_next       = pos_reg;
        sens_next      = sens_reg;
        acc_next       = acc_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        rounded_next   = rounded_reg;
        mode_next      = mode_reg;
        pump_next      = pump_reg;
        updated_next   = updated_reg;

        if (cmd.load_req)
        begin
            updated_next = 1'b0;
        end

        if (cmd.conv)
        begin
            if (pos_reg == POS_LAST)
            begin
                pos_next  = '0;
                sens_next = (sens_reg == SENS_LAST) ? '0 : sens_reg + SIDX_W'(1);
            end
            else
            begin
                pos_next = pos_reg + 2'd1;
            end
        end

        if (cmd.acc)
        begin
            acc_next = (acc_reg == SENS_LAST) ? '0 : acc_reg + SIDX_W'(1);
            if (med_ok)
            begin
                sum_next = sum_reg + SUM_W'(med_chain_reg[0][15:0]);
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end

        if (cmd.avg)
        begin
            sum_next = '0;
            cnt_next = '0;
        end

        if (cmd.exec_op)
        begin
            unique case (req_reg.operation)
                OP_MODE_BUTTON:
                begin
                    mode_next = !mode_reg;
                    if (!mode_reg && (rounded_reg < cfg.pump_stop_level))
                    begin
                        pump_next = 1'b1;
                    end
                end
                OP_PUMP_ON_BUTTON:
                begin
                    if (!mode_reg)
                    begin
                        pump_next = 1'b1;
                    end
                end
                OP_PUMP_OFF_BUTTON:
                begin
                    if (!mode_reg)
                    begin
                        pump_next = 1'b0;
                    end
                end
                OP_REMOTE_MODE:
                begin
                    mode_next = req_reg.set_value;
                end
                OP_REMOTE_PUMP:
                begin
                    if (!mode_reg)
                    begin
                        pump_next = req_reg.set_value;
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end

        if (cmd.level)
        begin
            rounded_next = level_new;
            updated_next = 1'b1;
            if (mode_reg)
            begin
                priority if (level_new <= cfg.pump_start_level)
                begin
                    pump_next = 1'b1;
                end
                else if (level_new >= cfg.pump_stop_level)
                begin
                    pump_next = 1'b0;
                end
                else
                begin
                    pump_next = pump_reg;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result
    // ------------------------------------------------------------------------
    always_comb
    begin
        rsp_next.level_percent  = rounded_reg;
        rsp_next.pump_on        = pump_reg;
        rsp_next.automatic_mode = mode_reg;
        rsp_next.led_bar        = {rounded_reg >= BAR_LEVEL_4,
                                   rounded_reg >= BAR_LEVEL_3,
                                   rounded_reg >= BAR_LEVEL_2,
                                   rounded_reg >= BAR_LEVEL_1,
                                   rounded_reg >= BAR_LEVEL_0};
        rsp_next.buzzer         = (rounded_reg < BUZZ_LOW) || (rounded_reg > BUZZ_HIGH);
        rsp_next.level_updated  = updated_reg;
    end

    always_comb
    begin
        priority if (cmd.emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            sens_reg      <= '0;
            acc_reg       <= '0;
            round_end_reg <= 1'b0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            smooth_reg    <= '0;
            rounded_reg   <= '0;
            mode_reg      <= 1'b1;
            pump_reg      <= 1'b0;
            updated_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            sens_reg      <= sens_next;
            acc_reg       <= acc_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            rounded_reg   <= rounded_next;
            mode_reg      <= mode_next;
            pump_reg      <= pump_next;
            updated_reg   <= updated_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cmd.conv)
            begin
                round_end_reg <= (pos_reg == POS_LAST) && (sens_reg == SENS_LAST);
            end
            if (cmd.filt_b)
            begin
                smooth_reg <= smooth_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        if (cmd.conv)
        begin
            d_reg <= dist_next;
            if (pos_reg == 2'd0)
            begin
                e0_reg <= dist_next;
            end
            if (pos_reg == 2'd1)
            begin
                e1_reg <= dist_next;
            end
        end
        if (cmd.med)
        begin
            for (int k = 0; k < SENSOR_COUNT - 1; k++)
            begin
                med_chain_reg[k] <= med_chain_reg[k + 1];
            end
            med_chain_reg[SENSOR_COUNT - 1] <= med_next;
        end
        if (cmd.acc)
        begin
            for (int k = 0; k < SENSOR_COUNT - 1; k++)
            begin
                med_chain_reg[k] <= med_chain_reg[k + 1];
            end
            med_chain_reg[SENSOR_COUNT - 1] <= med_chain_reg[0];
        end
        if (cmd.avg)
        begin
            x_reg <= x_next;
        end
        if (cmd.map)
        begin
            high_reg <= (x_reg <= X_FULL);
            q_reg    <= map_prod[MAP_SHIFT +: Q_W];
        end
        if (cmd.filt_a)
        begin
            raw_g_reg <= RAW_G_W'(raw_level) * RAW_G_W'(gain);
        end
        if (cmd.emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign status.req_echo  = (req.operation == OP_ECHO);
    assign status.third     = (pos_reg == POS_LAST);
    assign status.round_end = round_end_reg;
    assign status.acc_last  = (acc_reg == SENS_LAST);
    assign status.out_free  = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== sv/tank_level_pump_controller_core.sv =====
// ============================================================================
// tank_level_pump_controller_core
// Tank level and pump controller: echo rounds in, level, pump and alarms out.
// ============================================================================
// Usage:
//   req carries one transaction: an echo time or a button / remote event.
//   Echoes arrive three per sensor, sensor after sensor, SENSOR_COUNT sensors
//   per round. Every request transaction yields exactly one rsp transaction.
//   cfg writes one setting register by index; cfg_ready is always high, and
//   writes are to be made by the user only while no transaction is in flight;
//   the block itself has no guard for this.
// Steps from acceptance to next acceptance, ending in the emit step that loads the
//   result register: button / remote events and first two echoes of a sensor:
//   execute or convert; third echo of a sensor: also median; last echo of a round:
//   also median, range check and add per sensor, average, map, two filter
//   multiplies, rounding, hysteresis.
// Reset: mode automatic, pump off, level 0, round restarts, default settings.
// Stall: the result waits in the output register while rsp_ready is low; a new
//   request is accepted meanwhile and the sequencer holds in its last step.
// ============================================================================
`default_nettype none

module tank_level_pump_controller_core
    import tlpc_pkg::*;
#(
    parameter int SENSOR_COUNT = 3
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_ready,
    input  wire req_t                   req,
    output logic                        rsp_valid,
    input  wire logic                   rsp_ready,
    output rsp_t                        rsp,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t       cfg_reg;
    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PUMP_START:   cfg_reg.pump_start_level   <= cfg_data[6:0];
                CFG_PUMP_STOP:    cfg_reg.pump_stop_level    <= cfg_data[6:0];
                CFG_FILTER_GAIN:  cfg_reg.filter_gain        <= cfg_data[8:0];
                CFG_MIN_DISTANCE: cfg_reg.min_valid_distance <= cfg_data;
                CFG_MAX_DISTANCE: cfg_reg.max_valid_distance <= cfg_data;
                default:          cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    tlpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tlpc_datapath #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

`ifndef NO_ASSERTIONS
    a_single_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another transaction is in flight");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.level_percent <= LEVEL_MAX)
        else $error("level above full scale");

    a_bar_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.led_bar == 5'd0 || rsp.led_bar == 5'd1 || rsp.led_bar == 5'd3
                    || rsp.led_bar == 5'd7 || rsp.led_bar == 5'd15 || rsp.led_bar == 5'd31))
        else $error("LED bar is not a thermometer code");

    a_top_bar_buzzer: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.led_bar[4] |-> rsp.buzzer)
        else $error("top LED lit without high-level buzzer");
`endif

endmodule

`default_nettype wire

// ===== tb/tank_level_pump_controller_core_checker.sv =====
// ----------------------------------------------------------------------------
// Tank level pump controller status checker
// Watches the request, status and setting channels of the controller. Keeps
// its own copy of the echo round, smoothed level, mode, pump and settings.
// Predicts the status of each accepted request and compares it field by field
// with the status transactions as they are accepted.
// ----------------------------------------------------------------------------
module tank_level_pump_controller_core_checker
    import tlpc_pkg::*;
#(
    parameter int SENSOR_COUNT = 3
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic                   req_ready,
    input  req_t                   req,
    input  logic                   rsp_valid,
    input  logic                   rsp_ready,
    input  rsp_t                   rsp,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROUND_LEN    = 3 * SENSOR_COUNT;
    localparam int SOUND_NUM    = 2744;
    localparam int SOUND_DEN    = 1000;
    localparam int NO_ECHO_MM   = 110;
    localparam int FULL_MM      = 20;

    logic [16:0] echo_dist [ROUND_LEN];
    int unsigned echo_count;
    logic [14:0] smooth_q8;
    logic [6:0]  tank_level;
    logic        auto_mode;
    logic        pump_run;
    cfg_t        setting;

    rsp_t        expected_status [$];

    function automatic rsp_t tank_status(input req_t item);
        int unsigned sum;
        int unsigned cnt;
        int unsigned g;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned med;
        int          x;
        int          raw;
        rsp_t        r;
        r = '0;
        case (item.operation)
            OP_ECHO:
            begin
                if (echo_count >= ROUND_LEN)
                    echo_count = 0;
                if (item.echo_time == '0)
                    echo_dist[echo_count] = TIMEOUT_DIST;
                else
                    echo_dist[echo_count] = 17'((32'(item.echo_time) * SOUND_NUM) / SOUND_DEN);
                echo_count++;
                if (echo_count >= ROUND_LEN)
                begin
                    echo_count = 0;
                    sum = 0;
                    cnt = 0;
                    for (int k = 0; k < SENSOR_COUNT; k++)
                    begin
                        lo  = echo_dist[3*k] < echo_dist[3*k+1] ? echo_dist[3*k] : echo_dist[3*k+1];
                        hi  = echo_dist[3*k] < echo_dist[3*k+1] ? echo_dist[3*k+1] : echo_dist[3*k];
                        mid = hi < echo_dist[3*k+2] ? hi : echo_dist[3*k+2];
                        med = lo > mid ? lo : mid;
                        if (med >= setting.min_valid_distance && med <= setting.max_valid_distance)
                        begin
                            sum += med;
                            cnt++;
                        end
                    end
                    x = (cnt > 0) ? int'(sum / (16 * cnt)) : NO_ECHO_MM;
                    raw = 100 - ((x - FULL_MM) * 100) / 90;
                    if (raw < 0)
                        raw = 0;
                    if (raw > 100)
                        raw = 100;
                    g = setting.filter_gain > GAIN_MAX ? GAIN_MAX : setting.filter_gain;
                    smooth_q8 = 15'((int'(raw) * 256 * g + smooth_q8 * (256 - g) + 128) >> 8);
                    tank_level = 7'((smooth_q8 + 128) >> 8);
                    if (auto_mode)
                    begin
                        if (tank_level <= setting.pump_start_level)
                            pump_run = 1'b1;
                        else if (tank_level >= setting.pump_stop_level)
                            pump_run = 1'b0;
                    end
                    r.level_updated = 1'b1;
                end
            end
            OP_MODE_BUTTON:
            begin
                auto_mode = ~auto_mode;
                if (auto_mode && tank_level < setting.pump_stop_level)
                    pump_run = 1'b1;
            end
            OP_PUMP_ON_BUTTON:
            begin
                if (!auto_mode)
                    pump_run = 1'b1;
            end
            OP_PUMP_OFF_BUTTON:
            begin
                if (!auto_mode)
                    pump_run = 1'b0;
            end
            OP_REMOTE_MODE:
            begin
                auto_mode = item.set_value;
            end
            OP_REMOTE_PUMP:
            begin
                if (!auto_mode)
                    pump_run = item.set_value;
            end
            default:
            begin
            end
        endcase
        r.level_percent  = tank_level;
        r.pump_on        = pump_run;
        r.automatic_mode = auto_mode;
        r.led_bar        = {tank_level >= BAR_LEVEL_4, tank_level >= BAR_LEVEL_3,
                            tank_level >= BAR_LEVEL_2, tank_level >= BAR_LEVEL_1,
                            tank_level >= BAR_LEVEL_0};
        r.buzzer         = (tank_level < BUZZ_LOW) || (tank_level > BUZZ_HIGH);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < ROUND_LEN; k++)
                echo_dist[k] = '0;
            echo_count = 0;
            smooth_q8  = '0;
            tank_level = '0;
            auto_mode  = 1'b1;
            pump_run   = 1'b0;
            setting    = CFG_RESET;
            fail_count = 0;
            expected_status.delete();
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_status.size() == 0)
                begin
                    $error("status transaction with none expected: %h", rsp);
                    fail_count++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("level_percent", want.level_percent, rsp.level_percent);
                    check_field("pump_on", want.pump_on, rsp.pump_on);
                    check_field("automatic_mode", want.automatic_mode, rsp.automatic_mode);
                    check_field("led_bar", want.led_bar, rsp.led_bar);
                    check_field("buzzer", want.buzzer, rsp.buzzer);
                    check_field("level_updated", want.level_updated, rsp.level_updated);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PUMP_START:   setting.pump_start_level   = cfg_data[6:0];
                    CFG_PUMP_STOP:    setting.pump_stop_level    = cfg_data[6:0];
                    CFG_FILTER_GAIN:  setting.filter_gain        = cfg_data[8:0];
                    CFG_MIN_DISTANCE: setting.min_valid_distance = cfg_data;
                    CFG_MAX_DISTANCE: setting.max_valid_distance = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (req_valid && req_ready)
                expected_status.push_back(tank_status(req));
        end
        pending = expected_status.size();
    end

endmodule

// ===== tb/tank_level_pump_controller_core_tb.sv =====
// ----------------------------------------------------------------------------
// Tank level pump controller testbench
// Drives echo rounds, button and remote events into the controller with
// random idle gaps and status back-pressure, across several setting phases
// including the extremes. A checker beside the block predicts and compares
// every status transaction; this module gives the verdict.
// ----------------------------------------------------------------------------
module tank_level_pump_controller_core_tb;

    import tlpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SENSOR_COUNT = 3;
    localparam int ROUND_LEN    = 3 * SENSOR_COUNT;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 85;
    localparam int ECHO_MAX     = 32767;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_ready;
    req_t                   req;
    logic                   rsp_valid;
    logic                   rsp_ready;
    rsp_t                   rsp;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int sent_items  = 0;
    int tank_target = 300;
    bit steady      = 1'b0;

    tank_level_pump_controller_core #(
        .SENSOR_COUNT(SENSOR_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tank_level_pump_controller_core_checker #(
        .SENSOR_COUNT(SENSOR_COUNT)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL tank_level_pump_controller_core");
            $finish;
        end
    end

    function automatic int pause_len();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (steady || $urandom_range(0, 7) != 0)
                rsp_ready <= 1'b1;
            else
            begin
                rsp_ready <= 1'b0;
                repeat (pause_len() - 1) @(negedge clk);
            end
        end
    end

    task automatic send_request(input req_t item);
        int gap;
        gap = (steady || $urandom_range(0, 1) == 0) ? 0 : pause_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        if (item.operation <= OP_REMOTE_PUMP)
            sent_items++;
        @(negedge clk);
    endtask

    task automatic send_echo(input int t);
        send_request(req_t'{operation: OP_ECHO, echo_time: 15'(t), set_value: 1'($urandom)});
    endtask

    task automatic send_event(input logic [2:0] op, input logic setv);
        send_request(req_t'{operation: op, echo_time: 15'($urandom_range(0, ECHO_MAX)),
                            set_value: setv});
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_setting(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic apply_settings(input int start, input int stop, input int gain,
                                  input int min_d, input int max_d);
        wait_idle();
        write_setting(CFG_PUMP_START, CFG_DATA_W'(start));
        write_setting(CFG_PUMP_STOP, CFG_DATA_W'(stop));
        write_setting(CFG_FILTER_GAIN, CFG_DATA_W'(gain));
        write_setting(CFG_MIN_DISTANCE, CFG_DATA_W'(min_d));
        write_setting(CFG_MAX_DISTANCE, CFG_DATA_W'(max_d));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_round();
        int pick;
        if ($urandom_range(0, 3) == 0)
        begin
            pick = $urandom_range(0, 2);
            if (pick == 0)
                tank_target = $urandom_range(60, 130);
            else if (pick == 1)
                tank_target = $urandom_range(600, 720);
            else
                tank_target = $urandom_range(60, 720);
        end
        for (int k = 0; k < ROUND_LEN; k++)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                send_echo(0);
            else if (pick == 1)
                send_echo($urandom_range(0, ECHO_MAX));
            else
                send_echo($urandom_range(tank_target - 15, tank_target + 15));
            if ($urandom_range(0, 11) == 0)
                send_event(3'($urandom_range(1, 7)), 1'($urandom));
        end
    endtask

    task automatic run_phase(input int target);
        int  stop_at;
        bit  held;
        stop_at = sent_items + target;
        held    = 1'b0;
        while (sent_items < stop_at)
        begin
            steady = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) != 0)
                send_round();
            else
                repeat ($urandom_range(1, 4))
                    send_event(3'($urandom_range(0, 7)), 1'($urandom));
            if (!held && sent_items >= stop_at - target / 2)
            begin
                wait_idle();
                held = 1'b1;
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_event(3'd6, 1'b0);
        send_event(3'd7, 1'b1);
        send_event(OP_MODE_BUTTON, 1'b0);
        send_event(OP_PUMP_ON_BUTTON, 1'b1);
        send_event(OP_PUMP_OFF_BUTTON, 1'b0);
        send_event(OP_REMOTE_PUMP, 1'b1);
        send_event(OP_REMOTE_PUMP, 1'b0);
        send_event(OP_REMOTE_MODE, 1'b0);
        send_event(OP_MODE_BUTTON, 1'b1);
        send_event(OP_PUMP_OFF_BUTTON, 1'b1);
        send_event(OP_REMOTE_PUMP, 1'b0);
        send_event(OP_REMOTE_MODE, 1'b0);
        send_event(OP_REMOTE_MODE, 1'b1);
        send_echo(0);
        send_echo(ECHO_MAX);
        send_echo(25000);
        send_echo(87);
        send_echo(88);
        send_echo(500);
        send_echo(874);
        send_echo(875);
        send_echo(16384);

        run_phase(PHASE_ITEMS);
        apply_settings(0, 100, 256, 0, 65535);
        run_phase(PHASE_ITEMS);
        apply_settings(100, 0, 0, 65535, 0);
        run_phase(PHASE_ITEMS);
        apply_settings(127, 127, 511, 65535, 65535);
        run_phase(PHASE_ITEMS);
        apply_settings(30, 70, 64, 240, 2400);
        run_phase(PHASE_ITEMS);
        apply_settings($urandom_range(0, 50), $urandom_range(50, 100), $urandom_range(0, 256),
                       $urandom_range(0, 400), $urandom_range(1500, 3000));
        run_phase(PHASE_ITEMS);
        apply_settings(10, 90, 38, 240, 2400);
        run_phase(PHASE_ITEMS);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("PASS tank_level_pump_controller_core");
        else
            $display("FAIL tank_level_pump_controller_core");
        $finish;
    end

endmodule
